// File: sv/keyword_presence_detector_core_macros.svh
// assertion macros shared by the keyword presence detector checkers
`ifndef KEYWORD_PRESENCE_DETECTOR_CORE_MACROS_SVH
`define KEYWORD_PRESENCE_DETECTOR_CORE_MACROS_SVH

// checked only while out of reset
`define KPD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define KPD_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/kpd_pkg.sv
// types and constants shared by the keyword presence detector modules
`default_nettype none

package kpd_pkg;

    localparam int MAX_WORDS_DEF = 32;
    localparam int MAX_LEN_DEF   = 32;

    localparam int CHAR_W     = 8;
    localparam int WIDX_W     = 5;
    localparam int POS_W      = 5;
    localparam int FUNC_W     = 2;
    localparam int KLEN_W     = 6;   // stored keyword length, at most 32
    localparam int CMP_W      = 7;   // common width for length compares
    localparam int CFG_W      = 6;
    localparam int FOUND_W    = 32;
    localparam int S_TDATA_W  = 24;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_TEXT  = 2'd2,
        FUNC_EOL   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_CHAR,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [WIDX_W-1:0]   word_index;
        logic [POS_W-1:0]    char_pos;
        logic                eval;        // token ended non-empty and not too long
    } op_ctl_t;

endpackage

`default_nettype wire

// File: sv/keyword_presence_detector_core.sv
// words pass the front stage, the queue slot and the back end output register to m_
// one word per cycle unless m_tready stalls; match and found state update once a cycle
// keyword chars sit in one ram per keyword, all read in the cycle after the word is taken
// reset: synchronous active low; clears found flags, lengths, token state and valid bits
// keyword char rams are not cleared and need no clearing pass
`default_nettype none

module keyword_presence_detector_core #(
    parameter int MAX_WORDS = kpd_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = kpd_pkg::MAX_LEN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [kpd_pkg::CFG_W-1:0]         cfg_wr_data,   // word_count
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // word_index[4:0], char_pos[9:5], char_value[17:10], zero pad above
    input  wire logic [kpd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [kpd_pkg::FUNC_W-1:0]        s_tuser,       // func
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [kpd_pkg::FOUND_W-1:0]            m_tdata,       // found_mask
    output logic [0:0]                             m_tuser        // token_hit
);

    import kpd_pkg::*;

    localparam int TLEN_W = $clog2(MAX_LEN + 1);
    localparam int CTL_W  = $bits(op_ctl_t);
    localparam int Q_W    = CTL_W + TLEN_W + MAX_WORDS;

    logic                 f_valid;
    logic                 f_ready;
    op_ctl_t              f_ctl;
    logic [TLEN_W-1:0]    f_tok_len;
    logic [MAX_WORDS-1:0] f_eq;
    logic                 b_valid;
    logic                 b_ready;
    logic [Q_W-1:0]       b_data;
    op_ctl_t              b_ctl;
    logic [TLEN_W-1:0]    b_tok_len;
    logic [MAX_WORDS-1:0] b_eq;
    logic                 token_hit;

    kpd_front #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_func       (func_t'(s_tuser)),
        .in_word_index (s_tdata[4:0]),
        .in_char_pos   (s_tdata[9:5]),
        .in_char_value (s_tdata[17:10]),
        .out_valid     (f_valid),
        .out_ready     (f_ready),
        .out_ctl       (f_ctl),
        .out_tok_len   (f_tok_len),
        .out_eq        (f_eq)
    );

    kpd_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctl, f_tok_len, f_eq}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign {b_ctl, b_tok_len, b_eq} = b_data;

    kpd_back #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (b_valid),
        .in_ready     (b_ready),
        .in_ctl       (b_ctl),
        .in_tok_len   (b_tok_len),
        .in_eq        (b_eq),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_found_mask (m_tdata),
        .m_token_hit  (token_hit)
    );

    assign m_tuser = token_hit;

endmodule

`default_nettype wire

// File: sv/kpd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module kpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/kpd_front.sv
// front end: accepts words, tracks the token, reads keyword chars and classifies
`default_nettype none

module kpd_front #(
    parameter int MAX_WORDS = kpd_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = kpd_pkg::MAX_LEN_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire kpd_pkg::func_t                     in_func,
    input  wire logic [kpd_pkg::WIDX_W-1:0]         in_word_index,
    input  wire logic [kpd_pkg::POS_W-1:0]          in_char_pos,
    input  wire logic [kpd_pkg::CHAR_W-1:0]         in_char_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output kpd_pkg::op_ctl_t                        out_ctl,
    output logic [$clog2(MAX_LEN+1)-1:0]            out_tok_len,
    output logic [MAX_WORDS-1:0]                    out_eq
);

    import kpd_pkg::*;

    localparam int TLEN_W = $clog2(MAX_LEN + 1);
    localparam int AW     = $clog2(MAX_LEN);

    logic              accept;
    logic              load_ok;
    logic [TLEN_W-1:0] tok_len_reg, tok_len_next;
    logic              too_long_reg, too_long_next;
    logic              s1_valid_reg, s1_valid_next;
    op_ctl_t           s1_ctl_reg, ctl_next;
    logic [TLEN_W-1:0] s1_tok_len_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic [CHAR_W-1:0] rd_data [MAX_WORDS];
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    assign in_ready = !s1_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign load_ok  = (int'(in_word_index) < MAX_WORDS) && (int'(in_char_pos) < MAX_LEN);
    assign wr_addr  = AW'(in_char_pos);
    assign rd_addr  = AW'(tok_len_reg);

    always_comb begin
        tok_len_next        = tok_len_reg;
        too_long_next       = too_long_reg;
        ctl_next.kind       = OP_NONE;
        ctl_next.word_index = in_word_index;
        ctl_next.char_pos   = in_char_pos;
        ctl_next.eval       = (tok_len_reg != '0) && !too_long_reg;
        unique case (in_func)
            FUNC_LOAD: begin
                ctl_next.kind = load_ok ? OP_LOAD : OP_NONE;
            end
            FUNC_CLEAR: begin
                ctl_next.kind = OP_CLEAR;
            end
            FUNC_TEXT: begin
                if (in_char_value == SPACE_CHAR) begin
                    ctl_next.kind = OP_END;
                    tok_len_next  = '0;
                    too_long_next = 1'b0;
                end else if (tok_len_reg >= TLEN_W'(MAX_LEN)) begin
                    too_long_next = 1'b1;
                end else begin
                    ctl_next.kind = OP_CHAR;
                    tok_len_next  = tok_len_reg + TLEN_W'(1);
                end
            end
            FUNC_EOL: begin
                ctl_next.kind = OP_END;
                tok_len_next  = '0;
                too_long_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (out_ready) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_len_reg  <= '0;
            too_long_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                tok_len_reg  <= tok_len_next;
                too_long_reg <= too_long_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg     <= ctl_next;
            s1_tok_len_reg <= tok_len_reg;
            s1_char_reg    <= in_char_value;
        end
    end

    // one char ram per keyword, all read at the current token position
    for (genvar g = 0; g < MAX_WORDS; g++) begin : g_lane
        kpd_ram #(
            .WIDTH (CHAR_W),
            .DEPTH (MAX_LEN)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (accept && (in_func == FUNC_LOAD) && load_ok &&
                      (int'(in_word_index) == g)),
            .wr_addr (wr_addr),
            .wr_data (in_char_value),
            .rd_en   (accept),
            .rd_addr (rd_addr),
            .rd_data (rd_data[g])
        );
        assign out_eq[g] = (rd_data[g] == s1_char_reg);
    end

    assign out_valid   = s1_valid_reg;
    assign out_ctl     = s1_ctl_reg;
    assign out_tok_len = s1_tok_len_reg;

endmodule

`default_nettype wire

// File: sv/kpd_queue.sv
// short fifo between front and back end
`default_nettype none

module kpd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    import kpd_pkg::*;

    logic [WIDTH-1:0]   slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != Q_CNT_W'(Q_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/kpd_back.sv
// back end: keyword lengths, running match vector, found flags and output register
`default_nettype none

module kpd_back #(
    parameter int MAX_WORDS = kpd_pkg::MAX_WORDS_DEF,
    parameter int MAX_LEN   = kpd_pkg::MAX_LEN_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [kpd_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire kpd_pkg::op_ctl_t                  in_ctl,
    input  wire logic [$clog2(MAX_LEN+1)-1:0]      in_tok_len,
    input  wire logic [MAX_WORDS-1:0]              in_eq,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [kpd_pkg::FOUND_W-1:0]            m_found_mask,
    output logic                                   m_token_hit
);

    import kpd_pkg::*;

    localparam int EXT_W = MAX_WORDS + FOUND_W;

    logic [CFG_W-1:0]     word_count_reg;
    logic [MAX_WORDS-1:0] match_reg, match_next;
    logic [MAX_WORDS-1:0] found_reg, found_next;
    logic [KLEN_W-1:0]    len_reg [MAX_WORDS];
    logic [KLEN_W-1:0]    len_next [MAX_WORDS];
    logic [MAX_WORDS-1:0] active;
    logic [MAX_WORDS-1:0] hits;
    logic                 hit_next;
    logic                 pop;
    logic                 m_valid_reg, m_valid_next;
    logic [FOUND_W-1:0]   m_found_reg, m_found_next;
    logic                 m_hit_reg;
    logic [EXT_W-1:0]     found_ext;

    assign in_ready = !m_valid_reg || m_ready;
    assign pop      = in_valid && in_ready;

    always_comb begin
        match_next = match_reg;
        found_next = found_reg;
        len_next   = len_reg;
        hit_next   = 1'b0;
        for (int i = 0; i < MAX_WORDS; i++) begin
            active[i] = int'(word_count_reg) > i;
            hits[i]   = match_reg[i] && active[i] &&
                        (CMP_W'(len_reg[i]) == CMP_W'(in_tok_len));
        end
        if (pop) begin
            unique case (in_ctl.kind)
                OP_NONE: begin
                end
                OP_LOAD: begin
                    for (int i = 0; i < MAX_WORDS; i++) begin
                        if (int'(in_ctl.word_index) == i) begin
                            len_next[i] = KLEN_W'(in_ctl.char_pos) + KLEN_W'(1);
                            if (in_ctl.char_pos == '0) begin
                                found_next[i] = 1'b0;
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    found_next = '0;
                end
                OP_CHAR: begin
                    match_next = match_reg & in_eq;
                end
                OP_END: begin
                    if (in_ctl.eval) begin
                        found_next = found_reg | hits;
                        hit_next   = |hits;
                    end
                    match_next = '1;
                end
                default: begin
                end
            endcase
        end
    end

    assign found_ext    = {{FOUND_W{1'b0}}, found_next};
    assign m_found_next = found_ext[FOUND_W-1:0];

    always_comb begin
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            match_reg      <= '1;
            found_reg      <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_WORDS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                word_count_reg <= cfg_wr_data;
            end
            match_reg   <= match_next;
            found_reg   <= found_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_found_reg <= m_found_next;
            m_hit_reg   <= hit_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found_mask = m_found_reg;
    assign m_token_hit  = m_hit_reg;

endmodule

`default_nettype wire

// File: sv/kpd_checker.sv
// port-level checks for the keyword presence detector, bound to the top level
`default_nettype none

`include "keyword_presence_detector_core_macros.svh"

module kpd_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [0:0]  m_tuser
);

    // a stalled result word holds its value
    `KPD_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // reset empties the output register
    `KPD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

    // input side can only back up behind a waiting result
    `KPD_ASSERT(a_backpressure, !s_tready |-> m_tvalid, "s_tready low with no result pending")

endmodule

bind keyword_presence_detector_core kpd_checker u_kpd_checker (.*);

`default_nettype wire
